FILE: rtl/core/tcd_pkg.sv
// shared types and constants of the text charset detector
`default_nettype none
package tcd_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned CHARSET_W  = 2;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned HEAD_DEPTH = 3;
    localparam int unsigned PAIR_CNT_W = 2;

    // charset codes
    localparam logic [CHARSET_W-1:0] CS_UNKNOWN = 2'd0;
    localparam logic [CHARSET_W-1:0] CS_UTF8    = 2'd1;
    localparam logic [CHARSET_W-1:0] CS_UTF16LE = 2'd2;
    localparam logic [CHARSET_W-1:0] CS_UTF16BE = 2'd3;

    // byte-order mark bytes
    localparam logic [DATA_W-1:0] BOM_UTF8_0 = 8'hEF;
    localparam logic [DATA_W-1:0] BOM_UTF8_1 = 8'hBB;
    localparam logic [DATA_W-1:0] BOM_UTF8_2 = 8'hBF;
    localparam logic [DATA_W-1:0] BOM_FE     = 8'hFE;
    localparam logic [DATA_W-1:0] BOM_FF     = 8'hFF;

    // byte count thresholds for the marks
    localparam logic [CNT_W-1:0] CNT_UTF16_MIN = 3'd3;
    localparam logic [CNT_W-1:0] CNT_UTF8_MIN  = 3'd4;
    localparam logic [CNT_W-1:0] CNT_SAT       = 3'd4;

    // pair counter decision level
    localparam logic [PAIR_CNT_W-1:0] PAIR_LIMIT = 2'd3;

    typedef struct packed {
        logic                 found;
        logic [CHARSET_W-1:0] charset;
    } bom_stat_t;

    typedef struct packed {
        logic valid;    // no failure, nothing pending, multibyte seen
    } utf8_stat_t;

    typedef struct packed {
        logic                 decided;
        logic [CHARSET_W-1:0] verdict;
    } utf16_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/tcd_bom_det.sv
// byte-order mark detector over the first bytes of a buffer
`default_nettype none
module tcd_bom_det
    import tcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              clear,
    input  wire logic [DATA_W-1:0] data_byte,
    output bom_stat_t              stat
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] head_reg  [HEAD_DEPTH];
    logic [DATA_W-1:0] head_next [HEAD_DEPTH];

    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_next[i] = head_reg[i];
        end
        if (cnt_reg < CNT_W'(HEAD_DEPTH)) begin
            head_next[cnt_reg[1:0]] = data_byte;
        end
        if (cnt_reg < CNT_SAT) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        stat = '{found: 1'b0, charset: CS_UNKNOWN};
        if (cnt_next >= CNT_UTF8_MIN && head_next[0] == BOM_UTF8_0 &&
            head_next[1] == BOM_UTF8_1 && head_next[2] == BOM_UTF8_2) begin
            stat = '{found: 1'b1, charset: CS_UTF8};
        end else if (cnt_next >= CNT_UTF16_MIN && head_next[0] == BOM_FF &&
                     head_next[1] == BOM_FE) begin
            stat = '{found: 1'b1, charset: CS_UTF16LE};
        end else if (cnt_next >= CNT_UTF16_MIN && head_next[0] == BOM_FE &&
                     head_next[1] == BOM_FF) begin
            stat = '{found: 1'b1, charset: CS_UTF16BE};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            cnt_reg <= '0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= '0;
            end
        end else if (accept) begin
            cnt_reg <= cnt_next;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tcd_utf8_chk.sv
// utf-8 validator for one- to three-byte sequences
`default_nettype none
module tcd_utf8_chk
    import tcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              clear,
    input  wire logic [DATA_W-1:0] data_byte,
    output utf8_stat_t             stat
);

    logic [1:0] pend_reg, pend_next;
    logic       failed_reg, failed_next;
    logic       multi_reg, multi_next;

    always_comb begin
        pend_next   = pend_reg;
        failed_next = failed_reg;
        multi_next  = multi_reg;
        if (!failed_reg) begin
            if (pend_reg != 2'd0) begin
                if (data_byte[7:6] != 2'b10) begin
                    failed_next = 1'b1;
                end else begin
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1) begin
                        multi_next = 1'b1;
                    end
                end
            end else if (data_byte inside {[8'h00:8'h7F]}) begin
                pend_next = pend_reg;
            end else if (data_byte inside {[8'hC0:8'hDF]}) begin
                pend_next = 2'd1;
            end else if (data_byte inside {[8'hE0:8'hEF]}) begin
                pend_next = 2'd2;
            end else begin
                // stray continuation or four-byte and wider lead
                failed_next = 1'b1;
            end
        end
    end

    assign stat.valid = !failed_next && pend_next == 2'd0 && multi_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pend_reg   <= '0;
            failed_reg <= 1'b0;
            multi_reg  <= 1'b0;
        end else if (accept) begin
            pend_reg   <= pend_next;
            failed_reg <= failed_next;
            multi_reg  <= multi_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tcd_pair_cnt.sv
// utf-16 byte pair counters and decision
`default_nettype none
module tcd_pair_cnt
    import tcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              clear,
    input  wire logic [DATA_W-1:0] data_byte,
    output utf16_stat_t            stat
);

    logic [DATA_W-1:0]     first_reg, first_next;
    logic                  phase_reg, phase_next;
    logic [PAIR_CNT_W-1:0] le_reg, le_next;
    logic [PAIR_CNT_W-1:0] be_reg, be_next;
    logic [PAIR_CNT_W-1:0] err_reg, err_next;
    logic [CHARSET_W-1:0]  verdict_reg, verdict_next;
    logic                  decided_reg, decided_next;

    always_comb begin
        first_next   = first_reg;
        phase_next   = phase_reg;
        le_next      = le_reg;
        be_next      = be_reg;
        err_next     = err_reg;
        verdict_next = verdict_reg;
        decided_next = decided_reg;
        if (!phase_reg) begin
            first_next = data_byte;
            phase_next = 1'b1;
        end else begin
            phase_next = 1'b0;
            if (!decided_reg) begin
                if (first_reg != '0 && data_byte == '0) begin
                    le_next = le_reg + 1'b1;
                end else if (first_reg == '0 && data_byte != '0) begin
                    be_next = be_reg + 1'b1;
                end else begin
                    err_next = err_reg + 1'b1;
                end
                if (le_next == PAIR_LIMIT) begin
                    verdict_next = CS_UTF16LE;
                    decided_next = 1'b1;
                end else if (be_next == PAIR_LIMIT) begin
                    verdict_next = CS_UTF16BE;
                    decided_next = 1'b1;
                end else if (err_next == PAIR_LIMIT) begin
                    verdict_next = CS_UNKNOWN;
                    decided_next = 1'b1;
                end
            end
        end
    end

    assign stat.decided = decided_next;
    assign stat.verdict = verdict_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            first_reg   <= '0;
            phase_reg   <= 1'b0;
            le_reg      <= '0;
            be_reg      <= '0;
            err_reg     <= '0;
            verdict_reg <= CS_UNKNOWN;
            decided_reg <= 1'b0;
        end else if (accept) begin
            first_reg   <= first_next;
            phase_reg   <= phase_next;
            le_reg      <= le_next;
            be_reg      <= be_next;
            err_reg     <= err_next;
            verdict_reg <= verdict_next;
            decided_reg <= decided_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/text_charset_detector.sv
// top level of the text charset detector
// a verdict appears on the m_ side in the cycle after the request marked tlast is taken
// throughput: one byte per cycle; the single result register is refilled in the cycle
//   it is taken, so s_tready only drops while a verdict waits and m_tready is low
// reset: synchronous, active low; clears all scan state and empties the result register
// each verdict also returns the scan state to its reset value for the next buffer
`default_nettype none
module text_charset_detector
    import tcd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // byte stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // last byte of the buffer
    // verdict stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [1:0] charset, [7:2] zero
    output logic            m_tuser    // [0] has_bom
);

    logic                 s_accept;
    logic                 buf_end;
    bom_stat_t            bom_stat;
    utf8_stat_t           utf8_stat;
    utf16_stat_t          utf16_stat;

    logic                 m_valid_reg, m_valid_next;
    logic [CHARSET_W-1:0] charset_reg, charset_next;
    logic                 has_bom_reg, has_bom_next;

    // output slot is free when empty or being drained this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    // the last byte of a buffer closes it and resets all scan state
    assign buf_end  = s_accept && s_tlast;

    tcd_bom_det u_bom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .clear     (buf_end),
        .data_byte (s_tdata[DATA_W-1:0]),
        .stat      (bom_stat)
    );

    tcd_utf8_chk u_utf8 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .clear     (buf_end),
        .data_byte (s_tdata[DATA_W-1:0]),
        .stat      (utf8_stat)
    );

    tcd_pair_cnt u_pair (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .clear     (buf_end),
        .data_byte (s_tdata[DATA_W-1:0]),
        .stat      (utf16_stat)
    );

    // verdict priority: mark, then utf-8, then utf-16 pair counts
    always_comb begin
        charset_next = charset_reg;
        has_bom_next = has_bom_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (buf_end) begin
            m_valid_next = 1'b1;
            has_bom_next = 1'b0;
            if (bom_stat.found) begin
                charset_next = bom_stat.charset;
                has_bom_next = 1'b1;
            end else if (utf8_stat.valid) begin
                charset_next = CS_UTF8;
            end else if (utf16_stat.decided) begin
                charset_next = utf16_stat.verdict;
            end else begin
                charset_next = CS_UNKNOWN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        charset_reg <= charset_next;
        has_bom_reg <= has_bom_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(8 - CHARSET_W)'(0), charset_reg};
    assign m_tuser  = has_bom_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tcd_checker.sv
// port checker for the text charset detector and its bind
`default_nettype none
module tcd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser
);

    // a held verdict keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("verdict changed while stalled");

    // a closing byte always produces a verdict
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no verdict after last byte");

    // a mid-buffer byte never invents a verdict
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("verdict without last byte");

    // a mark always names a charset and the padding stays zero
    a_bom_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:2] == 6'd0 && (!m_tuser || m_tdata[1:0] != 2'd0))
        else $error("bad verdict encoding");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("verdict valid after reset");

endmodule

bind text_charset_detector tcd_checker u_tcd_checker (.*);
`default_nettype wire

FILE: sim/tb_top.sv
// self-checking testbench of the text charset detector: directed buffers, then random buffers
`timescale 1ns / 1ps
module tb_top;
    import tcd_pkg::*;

    localparam int RANDOM_BYTES = 1500;
    localparam int HOLD_AFTER   = 400;    // bytes taken before the long receiver hold
    localparam int HOLD_CYCLES  = 300;

    // one verdict as the m_ side carries it
    typedef struct packed {
        logic [CHARSET_W-1:0] charset;
        logic                 has_bom;
    } verdict_t;

    // one byte request; known rows carry a verdict typed in by hand
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              known;
        verdict_t          want;
    } byte_req_t;

    localparam verdict_t NO_V = '{CS_UNKNOWN, 1'b0};

    // directed buffers: marks at and under their length thresholds, empty-ish
    // buffers, a two-byte sequence, a cut-off sequence and unmarked utf-16
    localparam byte_req_t DIRECTED [26] = '{
        '{BOM_UTF8_0, 1'b0, 1'b0, NO_V},
        '{BOM_UTF8_1, 1'b0, 1'b0, NO_V},
        '{BOM_UTF8_2, 1'b0, 1'b0, NO_V},
        '{8'h41,      1'b1, 1'b1, '{CS_UTF8, 1'b1}},
        '{BOM_UTF8_0, 1'b0, 1'b0, NO_V},
        '{BOM_UTF8_1, 1'b0, 1'b0, NO_V},
        '{BOM_UTF8_2, 1'b1, 1'b0, NO_V},
        '{BOM_FF,     1'b0, 1'b0, NO_V},
        '{BOM_FE,     1'b0, 1'b0, NO_V},
        '{8'h00,      1'b1, 1'b1, '{CS_UTF16LE, 1'b1}},
        '{BOM_FE,     1'b0, 1'b0, NO_V},
        '{BOM_FF,     1'b0, 1'b0, NO_V},
        '{8'h41,      1'b1, 1'b1, '{CS_UTF16BE, 1'b1}},
        '{BOM_FF,     1'b0, 1'b0, NO_V},
        '{BOM_FE,     1'b1, 1'b0, NO_V},
        '{8'h00,      1'b1, 1'b1, '{CS_UNKNOWN, 1'b0}},
        '{8'hC3,      1'b0, 1'b0, NO_V},
        '{8'hA9,      1'b1, 1'b0, NO_V},
        '{8'hE2,      1'b0, 1'b0, NO_V},
        '{8'h82,      1'b1, 1'b0, NO_V},
        '{8'h00,      1'b0, 1'b0, NO_V},
        '{8'h41,      1'b0, 1'b0, NO_V},
        '{8'h00,      1'b0, 1'b0, NO_V},
        '{8'h42,      1'b0, 1'b0, NO_V},
        '{8'h00,      1'b0, 1'b0, NO_V},
        '{8'h43,      1'b1, 1'b0, NO_V}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              m_tuser;

    byte_req_t         text_q[$];       // every byte request, in send order
    verdict_t          verdict_q[$];    // verdicts still owed by the block
    int                bytes_taken = 0;
    int                fail_cnt    = 0;
    bit                stim_done   = 1'b0;
    bit                hold_done   = 1'b0;

    // scan state of the charset predictor
    logic [CNT_W-1:0]      seen_cnt;
    logic [DATA_W-1:0]     head [HEAD_DEPTH];
    logic [1:0]            cont_left;
    bit                    u8_bad;
    bit                    u8_multi;
    logic [DATA_W-1:0]     pair_lo;
    bit                    pair_half;
    logic [PAIR_CNT_W-1:0] le_cnt;
    logic [PAIR_CNT_W-1:0] be_cnt;
    logic [PAIR_CNT_W-1:0] err_cnt;
    logic [CHARSET_W-1:0]  u16_cs;
    bit                    u16_done;

    text_charset_detector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin : watchdog
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] rnd_byte(input int unsigned lo, input int unsigned hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic void clear_scan();
        seen_cnt  = '0;
        for (int i = 0; i < HEAD_DEPTH; i++) head[i] = '0;
        cont_left = '0;
        u8_bad    = 1'b0;
        u8_multi  = 1'b0;
        pair_lo   = '0;
        pair_half = 1'b0;
        le_cnt    = '0;
        be_cnt    = '0;
        err_cnt   = '0;
        u16_cs    = CS_UNKNOWN;
        u16_done  = 1'b0;
    endfunction

    // advance the predictor by one byte; returns 1 with a verdict on the last byte
    function automatic bit scan_byte(input logic [7:0] b, input logic lst, output verdict_t v);
        v = NO_V;
        if (seen_cnt < 3) head[seen_cnt] = b;
        if (seen_cnt < CNT_SAT) seen_cnt = seen_cnt + 1'b1;

        // utf-8 validator, 1- to 3-byte sequences only
        if (!u8_bad) begin
            if (cont_left != 0) begin
                if (b[7:6] != 2'b10) begin
                    u8_bad = 1'b1;
                end else begin
                    cont_left = cont_left - 1'b1;
                    if (cont_left == 0) u8_multi = 1'b1;
                end
            end else if (b >= 8'hF0 || b[7:6] == 2'b10) begin
                u8_bad = 1'b1;
            end else if (b >= 8'hE0) begin
                cont_left = 2'd2;
            end else if (b >= 8'hC0) begin
                cont_left = 2'd1;
            end
        end

        // aligned byte pairs for utf-16, frozen once decided
        if (!pair_half) begin
            pair_lo   = b;
            pair_half = 1'b1;
        end else begin
            pair_half = 1'b0;
            if (!u16_done) begin
                if (pair_lo != 0 && b == 0) le_cnt = le_cnt + 1'b1;
                else if (pair_lo == 0 && b != 0) be_cnt = be_cnt + 1'b1;
                else err_cnt = err_cnt + 1'b1;
                if (le_cnt >= PAIR_LIMIT) begin
                    u16_cs   = CS_UTF16LE;
                    u16_done = 1'b1;
                end else if (be_cnt >= PAIR_LIMIT) begin
                    u16_cs   = CS_UTF16BE;
                    u16_done = 1'b1;
                end else if (err_cnt >= PAIR_LIMIT) begin
                    u16_cs   = CS_UNKNOWN;
                    u16_done = 1'b1;
                end
            end
        end

        if (!lst) return 1'b0;

        if (seen_cnt >= CNT_UTF8_MIN && head[0] == BOM_UTF8_0 &&
            head[1] == BOM_UTF8_1 && head[2] == BOM_UTF8_2) begin
            v = '{CS_UTF8, 1'b1};
        end else if (seen_cnt >= CNT_UTF16_MIN && head[0] == BOM_FF && head[1] == BOM_FE) begin
            v = '{CS_UTF16LE, 1'b1};
        end else if (seen_cnt >= CNT_UTF16_MIN && head[0] == BOM_FE && head[1] == BOM_FF) begin
            v = '{CS_UTF16BE, 1'b1};
        end else if (!u8_bad && cont_left == 0 && u8_multi) begin
            v = '{CS_UTF8, 1'b0};
        end else if (u16_done) begin
            v = '{u16_cs, 1'b0};
        end
        clear_scan();
        return 1'b1;
    endfunction

    initial clear_scan();

    // reset, then wait for the last verdict and report
    initial begin : run_ctrl
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        // let the scoreboard log the final request first
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && verdict_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // byte sender: build all buffers, then send them in bursts with random gaps
    initial begin : byte_sender
        logic [7:0] bq[$];
        byte_req_t  req;
        int         idx;
        int         burst;
        int         gap;
        int         n;
        int         j;
        int         bias;

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;

        foreach (DIRECTED[k]) text_q.insert(text_q.size(), DIRECTED[k]);

        // mostly well-formed text of each kind, the rest noise and near misses
        while (text_q.size() < $size(DIRECTED) + RANDOM_BYTES) begin
            bq.delete();
            case ($urandom_range(0, 9))
                0, 1: begin
                    // unstructured noise
                    n = $urandom_range(1, 10);
                    repeat (n) bq.insert(bq.size(), rnd_byte(0, 255));
                end
                2, 3: begin
                    // a mark at the head, with a random tail that may or may not reach the threshold
                    case ($urandom_range(0, 2))
                        0: begin
                            bq.insert(bq.size(), BOM_UTF8_0);
                            bq.insert(bq.size(), BOM_UTF8_1);
                            bq.insert(bq.size(), BOM_UTF8_2);
                        end
                        1: begin
                            bq.insert(bq.size(), BOM_FF);
                            bq.insert(bq.size(), BOM_FE);
                        end
                        default: begin
                            bq.insert(bq.size(), BOM_FE);
                            bq.insert(bq.size(), BOM_FF);
                        end
                    endcase
                    n = $urandom_range(0, 4);
                    repeat (n) bq.insert(bq.size(), rnd_byte(0, 255));
                end
                4, 5, 6: begin
                    // utf-8 text, sometimes with a damaged byte or cut short
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        case ($urandom_range(0, 2))
                            0: bq.insert(bq.size(), rnd_byte(8'h00, 8'h7F));
                            1: begin
                                bq.insert(bq.size(), rnd_byte(8'hC0, 8'hDF));
                                bq.insert(bq.size(), rnd_byte(8'h80, 8'hBF));
                            end
                            default: begin
                                bq.insert(bq.size(), rnd_byte(8'hE0, 8'hEF));
                                bq.insert(bq.size(), rnd_byte(8'h80, 8'hBF));
                                bq.insert(bq.size(), rnd_byte(8'h80, 8'hBF));
                            end
                        endcase
                    end
                    if ($urandom_range(0, 5) == 0)
                        bq[$urandom_range(0, bq.size() - 1)] = rnd_byte(0, 255);
                    if ($urandom_range(0, 7) == 0 && bq.size() > 1)
                        void'(bq.pop_back());
                end
                7, 8: begin
                    // utf-16 text leaning one way, with stray pairs and an odd tail
                    bias = $urandom_range(0, 2);
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        j = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : bias;
                        case (j)
                            0: begin
                                bq.insert(bq.size(), rnd_byte(1, 255));
                                bq.insert(bq.size(), 8'h00);
                            end
                            1: begin
                                bq.insert(bq.size(), 8'h00);
                                bq.insert(bq.size(), rnd_byte(1, 255));
                            end
                            default: begin
                                bq.insert(bq.size(),
                                          $urandom_range(0, 1) ? 8'h00 : rnd_byte(1, 255));
                                bq.insert(bq.size(), bq[bq.size() - 1] == 8'h00 ?
                                          8'h00 : rnd_byte(1, 255));
                            end
                        endcase
                    end
                    if ($urandom_range(0, 3) == 0) bq.insert(bq.size(), rnd_byte(0, 255));
                end
                default: begin
                    // near misses of the marks
                    case ($urandom_range(0, 2))
                        0: bq.insert(bq.size(), BOM_UTF8_0);
                        1: bq.insert(bq.size(), BOM_FF);
                        default: bq.insert(bq.size(), BOM_FE);
                    endcase
                    case ($urandom_range(0, 3))
                        0: bq.insert(bq.size(), BOM_UTF8_1);
                        1: bq.insert(bq.size(), BOM_FE);
                        2: bq.insert(bq.size(), BOM_FF);
                        default: bq.insert(bq.size(), rnd_byte(0, 255));
                    endcase
                    n = $urandom_range(0, 3);
                    repeat (n)
                        bq.insert(bq.size(),
                                  $urandom_range(0, 1) ? BOM_UTF8_2 : rnd_byte(0, 255));
                end
            endcase
            for (j = 0; j < bq.size(); j++) begin
                req.data  = bq[j];
                req.last  = (j == bq.size() - 1);
                req.known = 1'b0;
                req.want  = NO_V;
                text_q.insert(text_q.size(), req);
            end
        end

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        idx = 0;
        while (idx < text_q.size()) begin
            burst = $urandom_range(1, 48);
            while (burst > 0 && idx < text_q.size()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= text_q[idx].data;
                s_tlast  <= text_q[idx].last;
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                idx++;
                burst--;
            end
            // a quarter of the bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // verdict receiver: stall patterns of its own, plus one long hold to back up the input
    initial begin : verdict_sink
        int          mode;
        int          span;
        logic [31:0] pat;

        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && bytes_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            pat  = $urandom | 32'h1;
            span = $urandom_range(16, 160);
            for (int i = 0; i < span; i++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= pat[i % 32];
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
                @(posedge aclk);
            end
        end
    end

    // scoreboard: predict on each byte request, compare on each verdict request
    always @(posedge aclk) begin : scoreboard
        verdict_t  want;
        verdict_t  pred;
        byte_req_t req;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict with none expected: charset %0d has_bom %0d",
                           m_tdata[CHARSET_W-1:0], m_tuser);
                    fail_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[CHARSET_W-1:0] !== want.charset) begin
                        $error("charset mismatch: expected %0d, actual %0d",
                               want.charset, m_tdata[CHARSET_W-1:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[7:CHARSET_W] !== '0) begin
                        $error("tdata padding mismatch: expected 0, actual %0h",
                               m_tdata[7:CHARSET_W]);
                        fail_cnt++;
                    end
                    if (m_tuser !== want.has_bom) begin
                        $error("has_bom mismatch: expected %0d, actual %0d",
                               want.has_bom, m_tuser);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req = text_q[bytes_taken];
                bytes_taken++;
                if (scan_byte(req.data, req.last, pred))
                    verdict_q.insert(verdict_q.size(), req.known ? req.want : pred);
            end
        end
    end

endmodule
